// ----- hw/rtl/mrfr_pkg.sv -----
// mrfr_pkg: shared constants, codes and item types of the multi-reader frame ring
// used by every module of the ring; depends on nothing
`default_nettype none

package mrfr_pkg;

    localparam int CAPACITY    = 1024;
    localparam int SLOT_COUNT  = CAPACITY + 1;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int MAX_READERS = 8;
    localparam int RDR_W       = 3;
    localparam int CNT_W       = $clog2(MAX_READERS + 1);
    localparam int SAMPLE_W    = 16;
    localparam int FRAME_W     = 2 * SAMPLE_W;

    localparam int OP_W       = 2;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int RC_W       = 4;
    localparam int TC_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_T0   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_T1   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_READER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT  = 1'd1;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
    localparam logic [KIND_W-1:0] K_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] K_READ  = 3'd2;
    localparam logic [KIND_W-1:0] K_BADRD = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR = 3'd4;

    localparam int SEL_W = 2;
    localparam logic [SEL_W-1:0] SEL_T0   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_T1   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_MEAN = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] active;
        logic             two_tracks;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [RDR_W-1:0]           reader;
        logic [SEL_W-1:0]           sel;
        logic                       rd_ok;
    } t_item;

endpackage

`default_nettype wire

// ----- hw/rtl/mrfr_front.sv -----
// mrfr_front: decodes an incoming item into a kind, a track select and a reader check
// depends on mrfr_pkg
`default_nettype none

module mrfr_front
    import mrfr_pkg::*;
(
    input  wire t_cfg                       i_cfg,
    input  wire logic [OP_W-1:0]            i_operation,
    input  wire logic signed [SAMPLE_W-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_right_sample,
    input  wire logic [RDR_W-1:0]           i_reader,
    input  wire logic [MODE_W-1:0]          i_read_mode,
    output t_item                           o_item
);

    logic rd_ok;

    assign rd_ok = (CNT_W'(i_reader) < i_cfg.active);

    always_comb begin
        o_item.left   = i_left_sample;
        o_item.right  = i_right_sample;
        o_item.reader = i_reader;
        o_item.rd_ok  = rd_ok;

        unique case (i_operation)
            OP_WRITE: o_item.kind = K_WRITE;
            OP_READ:  o_item.kind = rd_ok ? K_READ : K_BADRD;
            OP_CLEAR: o_item.kind = K_CLEAR;
            default:  o_item.kind = K_NOP;
        endcase

        // one track: every mode reads track 0
        if (!i_cfg.two_tracks) begin
            o_item.sel = SEL_T0;
        end else if (i_read_mode == MODE_T1) begin
            o_item.sel = SEL_T1;
        end else if (i_read_mode == MODE_MEAN) begin
            o_item.sel = SEL_MEAN;
        end else begin
            o_item.sel = SEL_T0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mrfr_queue.sv -----
// mrfr_queue: two-entry item queue between the decode front and the execution back
// depends on mrfr_pkg
`default_nettype none

module mrfr_queue
    import mrfr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item                r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp;
    logic [Q_PTR_W-1:0]   r_rp;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_PTR_W-1:0]   n_wp;
    logic [Q_PTR_W-1:0]   n_rp;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_entry[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- hw/rtl/mrfr_back.sv -----
// mrfr_back: executes queued items against the frame store and reader pointers
// depends on mrfr_pkg; holds the frame store memory
`default_nettype none

module mrfr_back
    import mrfr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire logic                i_q_valid,
    input  wire t_item               i_q_item,
    output logic                     o_q_pop,
    output logic                     o_result_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic [SLOT_W-1:0]        o_write_free,
    output logic [SLOT_W-1:0]        o_read_avail
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_POST = 2'd3;

    localparam logic [SLOT_W-1:0] CAP_V = SLOT_W'(CAPACITY);

    logic [FRAME_W-1:0]        r_store [SLOT_COUNT];
    logic [FRAME_W-1:0]        r_rdata;
    logic [1:0]                r_state, n_state;
    t_item                     r_item, n_item;
    logic [SLOT_W-1:0]         r_wslot, n_wslot;
    logic [SLOT_W-1:0]         r_rslot [MAX_READERS];
    logic [SLOT_W-1:0]         n_rslot [MAX_READERS];
    logic [SLOT_W-1:0]         r_lag [MAX_READERS];
    logic [SLOT_W-1:0]         n_lag [MAX_READERS];
    logic [SLOT_W-1:0]         r_worst;
    logic [SLOT_W-1:0]         worst;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic [SLOT_W-1:0]         r_free, n_free;
    logic [SLOT_W-1:0]         r_avail, n_avail;
    logic                      r_valid, n_valid;
    logic                      free_ok;
    logic                      mem_we;
    logic                      mem_re;
    logic signed [SAMPLE_W:0]  pair_sum;

    // largest lag over the active readers
    always_comb begin
        worst = '0;
        for (int i = 0; i < MAX_READERS; i++) begin
            if ((CNT_W'(i) < i_cfg.active) && (r_lag[i] > worst)) begin
                worst = r_lag[i];
            end
        end
    end

    assign free_ok  = (i_cfg.active != '0) && (r_worst != CAP_V);
    assign pair_sum = {r_rdata[SAMPLE_W-1], r_rdata[SAMPLE_W-1:0]}
                    + {r_rdata[FRAME_W-1], r_rdata[FRAME_W-1:SAMPLE_W]};

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_wslot  = r_wslot;
        n_rslot  = r_rslot;
        n_lag    = r_lag;
        n_status = r_status;
        n_sample = r_sample;
        n_free   = r_free;
        n_avail  = r_avail;
        n_valid  = 1'b0;
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_status = STS_DONE;
                n_sample = '0;
                n_state  = ST_POST;
                unique case (r_item.kind)
                    K_WRITE: begin
                        if (free_ok) begin
                            mem_we  = 1'b1;
                            n_wslot = (r_wslot == CAP_V) ? '0 : r_wslot + 1'b1;
                            for (int i = 0; i < MAX_READERS; i++) begin
                                n_lag[i] = (r_lag[i] == CAP_V) ? '0 : r_lag[i] + 1'b1;
                            end
                        end else begin
                            n_status = STS_FULL;
                        end
                    end
                    K_READ: begin
                        if (r_lag[r_item.reader] == '0) begin
                            n_status = STS_EMPTY;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = ST_READ;
                        end
                    end
                    K_BADRD: begin
                        n_status = STS_RANGE;
                    end
                    K_CLEAR: begin
                        n_wslot = '0;
                        for (int i = 0; i < MAX_READERS; i++) begin
                            n_rslot[i] = '0;
                            n_lag[i]   = '0;
                        end
                    end
                    default: begin
                        n_status = STS_DONE;
                    end
                endcase
            end
            ST_READ: begin
                unique case (r_item.sel)
                    SEL_T1:   n_sample = r_rdata[FRAME_W-1:SAMPLE_W];
                    SEL_MEAN: n_sample = SAMPLE_W'(pair_sum >>> 1);
                    default:  n_sample = r_rdata[SAMPLE_W-1:0];
                endcase
                n_rslot[r_item.reader] = (r_rslot[r_item.reader] == CAP_V) ? '0
                                       : r_rslot[r_item.reader] + 1'b1;
                n_lag[r_item.reader]   = r_lag[r_item.reader] - 1'b1;
                n_state = ST_POST;
            end
            ST_POST: begin
                n_free  = (i_cfg.active == '0) ? '0 : CAP_V - worst;
                n_avail = r_item.rd_ok ? r_lag[r_item.reader] : '0;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wslot <= '0;
            r_valid <= 1'b0;
            r_worst <= '0;
            for (int i = 0; i < MAX_READERS; i++) begin
                r_rslot[i] <= '0;
                r_lag[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_wslot <= n_wslot;
            r_valid <= n_valid;
            r_worst <= worst;
            r_rslot <= n_rslot;
            r_lag   <= n_lag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_sample <= n_sample;
        r_free   <= n_free;
        r_avail  <= n_avail;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wslot] <= {r_item.right, r_item.left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_store[r_rslot[r_item.reader]];
        end
    end

    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_sample       = r_sample;
    assign o_write_free   = r_free;
    assign o_read_avail   = r_avail;

    a_strobe_after_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == ST_POST)
        else $error("result strobe without finishing an item");

    a_worst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (r_worst <= CAP_V))
        else $error("active reader lag above capacity");

    a_drop_holds_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_item.kind == K_WRITE && !free_ok)
        |=> ($stable(r_wslot) && r_status == STS_FULL))
        else $error("dropped write moved the write slot");

endmodule

`default_nettype wire

// ----- hw/rtl/multi_reader_frame_ring.sv -----
// multi_reader_frame_ring: top level; configuration registers, front, queue and back
// start pushes an item into the queue; the back pops it in idle and runs exec, then read for a
// read that returns a sample, then post and the result strobe; the back works one item at a time
// busy rises when the two-entry queue is full; the receiver cannot stall results
// reset (synchronous, active low) zeroes all pointers, sets one reader and two tracks
`default_nettype none

module multi_reader_frame_ring
    import mrfr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [OP_W-1:0]        i_operation,
    input  wire logic signed [SAMPLE_W-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_right_sample,
    input  wire logic [RDR_W-1:0]       i_reader,
    input  wire logic [MODE_W-1:0]      i_read_mode,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                        o_result_valid,
    output logic [STATUS_W-1:0]         o_status,
    output logic signed [SAMPLE_W-1:0]  o_sample,
    output logic [SLOT_W-1:0]           o_write_free,
    output logic [SLOT_W-1:0]           o_read_avail
);

    logic [RC_W-1:0] r_reader_count;
    logic [TC_W-1:0] r_track_count;
    t_cfg            cfg;
    t_item           front_item;
    t_item           q_item;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reader_count <= RC_W'(1);
            r_track_count  <= TC_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_READER_COUNT: r_reader_count <= i_cfg_data[RC_W-1:0];
                CFG_TRACK_COUNT:  r_track_count  <= i_cfg_data[TC_W-1:0];
                default: ;
            endcase
        end
    end

    // reader count saturates at the reader limit
    assign cfg.active = (r_reader_count > RC_W'(MAX_READERS)) ? CNT_W'(MAX_READERS)
                      : CNT_W'(r_reader_count);
    assign cfg.two_tracks = (r_track_count >= TC_W'(2));

    assign busy = q_full;

    mrfr_front u_front (
        .i_cfg          (cfg),
        .i_operation    (i_operation),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_reader       (i_reader),
        .i_read_mode    (i_read_mode),
        .o_item         (front_item)
    );

    mrfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    mrfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_sample       (o_sample),
        .o_write_free   (o_write_free),
        .o_read_avail   (o_read_avail)
    );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for the multi-reader frame ring, predicting every result
// from a model of the ring and comparing it with the block's result ports
// depends on mrfr_pkg and multi_reader_frame_ring
module tb_top;
    import mrfr_pkg::*;

    localparam logic [OP_W-1:0]   OP_IDLE    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_ALT_T0 = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [RDR_W-1:0]           rdr;
        logic [MODE_W-1:0]          mode;
    } ring_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [SAMPLE_W-1:0] sample;
        logic [SLOT_W-1:0]          write_free;
        logic [SLOT_W-1:0]          read_avail;
    } frame_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [OP_W-1:0]            i_operation = OP_IDLE;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic [RDR_W-1:0]           i_reader = '0;
    logic [MODE_W-1:0]          i_read_mode = MODE_T0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_READER_COUNT;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       o_result_valid;
    logic [STATUS_W-1:0]        o_status;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic [SLOT_W-1:0]          o_write_free;
    logic [SLOT_W-1:0]          o_read_avail;

    multi_reader_frame_ring i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_reader       (i_reader),
        .i_read_mode    (i_read_mode),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_sample       (o_sample),
        .o_write_free   (o_write_free),
        .o_read_avail   (o_read_avail)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ring model state
    logic [FRAME_W-1:0] frame_mem [SLOT_COUNT];
    int                 wr_ptr = 0;
    int                 rd_ptr [MAX_READERS] = '{default: 0};
    logic [RC_W-1:0]    reader_count_reg = 4'd1;
    logic [TC_W-1:0]    track_count_reg = 2'd2;

    ring_cmd_t     pending_cmds [$];
    frame_result_t expected_results [$];
    int            n_queued = 0;
    int            n_accepted = 0;
    int            n_errors = 0;

    function automatic int active_readers();
        return (reader_count_reg > MAX_READERS) ? MAX_READERS : int'(reader_count_reg);
    endfunction

    function automatic int ring_lag(input int r);
        return (wr_ptr >= r) ? wr_ptr - r : SLOT_COUNT - r + wr_ptr;
    endfunction

    function automatic int ring_free();
        int act;
        int worst;
        act = active_readers();
        worst = 0;
        if (act == 0) begin
            return 0;
        end
        for (int i = 0; i < act; i++) begin
            if (ring_lag(rd_ptr[i]) > worst) begin
                worst = ring_lag(rd_ptr[i]);
            end
        end
        return CAPACITY - worst;
    endfunction

    function automatic frame_result_t ring_apply(input ring_cmd_t c);
        frame_result_t              res;
        logic                       rd_ok;
        logic [FRAME_W-1:0]         frame;
        logic signed [SAMPLE_W-1:0] t0;
        logic signed [SAMPLE_W-1:0] t1;
        logic signed [SAMPLE_W:0]   pair_sum;
        res = '0;
        rd_ok = int'(c.rdr) < active_readers();
        if (c.op == OP_WRITE) begin
            if (ring_free() == 0) begin
                res.status = STS_FULL;
            end else begin
                frame_mem[wr_ptr] = {c.right, c.left};
                wr_ptr = (wr_ptr + 1) % SLOT_COUNT;
            end
        end else if (c.op == OP_READ) begin
            if (!rd_ok) begin
                res.status = STS_RANGE;
            end else if (ring_lag(rd_ptr[c.rdr]) == 0) begin
                res.status = STS_EMPTY;
            end else begin
                frame = frame_mem[rd_ptr[c.rdr]];
                t0 = frame[SAMPLE_W-1:0];
                t1 = (track_count_reg >= 2) ? frame[FRAME_W-1:SAMPLE_W] : t0;
                pair_sum = t0 + t1;
                case (c.mode)
                    MODE_T1: res.sample = t1;
                    MODE_MEAN: res.sample = pair_sum[SAMPLE_W:1];
                    default: res.sample = t0;
                endcase
                rd_ptr[c.rdr] = (rd_ptr[c.rdr] + 1) % SLOT_COUNT;
            end
        end else if (c.op == OP_CLEAR) begin
            wr_ptr = 0;
            foreach (rd_ptr[i]) rd_ptr[i] = 0;
        end
        res.write_free = SLOT_W'(ring_free());
        res.read_avail = rd_ok ? SLOT_W'(ring_lag(rd_ptr[c.rdr])) : '0;
        return res;
    endfunction

    function automatic ring_cmd_t mk_cmd(input logic [OP_W-1:0] op,
                                         input logic [SAMPLE_W-1:0] left,
                                         input logic [SAMPLE_W-1:0] right,
                                         input logic [RDR_W-1:0] rdr,
                                         input logic [MODE_W-1:0] mode);
        ring_cmd_t c;
        c.op = op;
        c.left = left;
        c.right = right;
        c.rdr = rdr;
        c.mode = mode;
        return c;
    endfunction

    function automatic void queue_cmd(input ring_cmd_t c);
        pending_cmds.push_back(c);
        n_queued++;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void add_random(input int n, input int wr_pct, input int rd_pct,
                                       input int clr_pct);
        int               roll;
        logic [OP_W-1:0]  op;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < wr_pct) begin
                op = OP_WRITE;
            end else if (roll < wr_pct + rd_pct) begin
                op = OP_READ;
            end else if (roll < wr_pct + rd_pct + clr_pct) begin
                op = OP_CLEAR;
            end else begin
                op = OP_IDLE;
            end
            queue_cmd(mk_cmd(op, pick_sample(), pick_sample(), RDR_W'($urandom_range(7)),
                             MODE_W'($urandom_range(3))));
        end
    endfunction

    // mostly short gaps, a few long ones, and occasional runs with none
    int burst_left = 0;

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(99) < 3) begin
            burst_left = $urandom_range(20, 60);
        end
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // driver
    ring_cmd_t cur_cmd;
    int        idle_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(ring_apply(cur_cmd));
                n_accepted++;
            end
            if (!(start && busy)) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_operation <= cur_cmd.op;
                    i_left_sample <= cur_cmd.left;
                    i_right_sample <= cur_cmd.right;
                    i_reader <= cur_cmd.rdr;
                    i_read_mode <= cur_cmd.mode;
                    start <= 1'b1;
                    idle_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : result_check
        frame_result_t want;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("unexpected result: status %0d sample %0d free %0d avail %0d",
                                     o_status, o_sample, o_write_free, o_read_avail));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_sample !== want.sample ||
                    o_write_free !== want.write_free || o_read_avail !== want.read_avail) begin
                    flag_error($sformatf({"mismatch: expected status %0d sample %0d free %0d ",
                                          "avail %0d, got status %0d sample %0d free %0d avail %0d"},
                                         want.status, want.sample, want.write_free,
                                         want.read_avail, o_status, o_sample, o_write_free,
                                         o_read_avail));
                end
            end
        end
    end

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_READER_COUNT) begin
            reader_count_reg = val[RC_W-1:0];
        end else begin
            track_count_reg = val[TC_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        // one reader, two tracks
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd1, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'h8000, 16'h7fff, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'h7fff, 16'h8000, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'hffff, 16'h0001, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'h0000, 16'hffff, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'h8000, 16'h8000, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'h7fff, 16'h7fff, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_MEAN));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_T1));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_MEAN));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_ALT_T0));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_MEAN));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_MEAN));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_IDLE, 16'h1234, 16'h5678, 3'd5, MODE_T1));
        queue_cmd(mk_cmd(OP_WRITE, pick_sample(), pick_sample(), 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, pick_sample(), pick_sample(), 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_CLEAR, 16'hffff, 16'hffff, 3'd7, MODE_ALT_T0));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd7, MODE_T0));
        queue_cmd(mk_cmd(OP_WRITE, 16'h8001, 16'h0002, 3'd0, MODE_T0));
        queue_cmd(mk_cmd(OP_READ, 16'h0000, 16'h0000, 3'd0, MODE_T0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // no active readers
        write_cfg(CFG_READER_COUNT, 4'd0);
        add_random(12, 50, 40, 0);
        wait_drained();

        // reader count above the maximum, one track
        write_cfg(CFG_READER_COUNT, 4'd15);
        write_cfg(CFG_TRACK_COUNT, 4'd1);
        add_random(300, 45, 50, 3);
        wait_drained();

        // two readers, track count three: fill to full then work near the limit
        write_cfg(CFG_READER_COUNT, 4'd2);
        write_cfg(CFG_TRACK_COUNT, 4'd3);
        add_random(1040, 100, 0, 0);
        add_random(120, 40, 60, 0);
        wait_drained();

        // all readers, stale pointers of the inactive ones come back
        write_cfg(CFG_READER_COUNT, 4'd8);
        write_cfg(CFG_TRACK_COUNT, 4'd2);
        add_random(250, 50, 46, 2);
        wait_drained();

        write_cfg(CFG_READER_COUNT, 4'd5);
        write_cfg(CFG_TRACK_COUNT, 4'd0);
        add_random(100, 50, 47, 1);

        while (n_accepted != n_queued) @(negedge i_clk);
        for (int w = 0; w < 100 && expected_results.size() != 0; w++) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
